FILE: sv/fetp_pkg.sv
`timescale 1ns / 1ps
package fetp_pkg;

    // image geometry
    localparam int IMG_WIDTH  = 1024;
    localparam int IMG_HEIGHT = 1024;
    localparam int PIX_W      = 10;
    localparam int IMG_MAX    = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
    // largest |2p - size| over the pixel range
    localparam int MAG_MAX    = (IMG_MAX > 2 * ((1 << PIX_W) - 1)) ? IMG_MAX
                                                                   : 2 * ((1 << PIX_W) - 1);
    localparam int MAG_W      = $clog2(MAG_MAX + 1);

    // pixel map divider: q = (|n| * 10 * 2^92) / (7 * size * zoom)
    // numerator >> 63 is |n| * 10 * 2^29, its low 63 bits are zero
    localparam int NUM_SH     = 29;
    localparam int NUM_W      = MAG_W + 4 + NUM_SH;
    localparam int DEN_K_X    = 7 * IMG_WIDTH;
    localparam int DEN_K_Y    = 7 * IMG_HEIGHT;
    localparam int DEN_W      = 64 + $clog2(7 * IMG_MAX + 1);
    localparam int REM_W      = DEN_W + 1;
    localparam int QUO_W      = 63;
    localparam int QCNT_W     = $clog2(QUO_W);

    // job queue, depth a power of two
    localparam int QDEPTH     = 2;
    localparam int QA_W       = $clog2(QDEPTH);

    localparam int CFG_IDX_W  = 3;

    // Q4.60 constants
    localparam logic signed [63:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic [63:0]        Q_FOUR = 64'h4000_0000_0000_0000;
    localparam logic signed [63:0] MB_SHIFT_RE = -64'sd883137872528844784;
    localparam logic signed [63:0] MB_SHIFT_IM = -64'sd115176858310224013;
    localparam logic signed [63:0] BS_SHIFT_RE = -64'sd461168601842738790;
    localparam logic signed [63:0] BS_SHIFT_IM = -64'sd576460752303423488;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_MAXIT  = 3'd1,
        CFG_ZOOM   = 3'd2,
        CFG_OFF_RE = 3'd3,
        CFG_OFF_IM = 3'd4,
        CFG_JUL_RE = 3'd5,
        CFG_JUL_IM = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_MANDEL = 2'd0,
        MODE_JULIA  = 2'd1,
        MODE_SHIP   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_ADD,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_MUL,
        B_EVAL,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] out_x;
        logic [PIX_W-1:0] out_y;
        logic [15:0]      escape_count;
        logic             inside_set;
    } t_result;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic signed [63:0] zx;
        logic signed [63:0] zy;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic               ship;
    } t_job;

    // saturating Q4.60 add
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sadd = s[64] ? Q_MIN : Q_MAX;
        end else begin
            sadd = s[63:0];
        end
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        mag64 = a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] sat_abs(input logic signed [63:0] a);
        if (a == Q_MIN) begin
            sat_abs = Q_MAX;
        end else if (a[63]) begin
            sat_abs = 64'sd0 - a;
        end else begin
            sat_abs = a;
        end
    endfunction

    // square: product >> 60, nonnegative, saturated
    function automatic logic signed [63:0] sq_sat(input logic [127:0] p);
        if (|p[127:123]) begin
            sq_sat = Q_MAX;
        end else begin
            sq_sat = {1'b0, p[122:60]};
        end
    endfunction

    // cross term: product >> 59 with sign, saturated
    function automatic logic signed [63:0] cross_sat(input logic [127:0] p, input logic neg);
        logic [63:0] m;
        logic        big;
        m   = {1'b0, p[121:59]};
        big = |p[127:122];
        if (neg) begin
            cross_sat = big ? Q_MIN : (64'd0 - m);
        end else begin
            cross_sat = big ? Q_MAX : m;
        end
    endfunction

endpackage

FILE: sv/fetp_div.sv
`timescale 1ns / 1ps
module fetp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fetp_pkg::MAG_W-1:0]    i_mag,
    input  logic [fetp_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic                          o_sat,
    output logic [fetp_pkg::QUO_W-1:0]    o_quo
);
    import fetp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;
    logic              r_sat;

    logic [NUM_W-1:0]  w_num;
    logic [REM_W-1:0]  w_shift;
    logic              w_ge;

    // |n| * 10, aligned to numerator >> 63
    assign w_num   = ((NUM_W'(i_mag) << 3) + (NUM_W'(i_mag) << 1)) << NUM_SH;
    assign w_shift = {r_rem[REM_W-2:0], 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle, zeros shifted in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(w_num);
            r_den <= i_den;
            r_sat <= REM_W'(w_num) >= REM_W'(i_den);
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quo  = r_quo;

endmodule

FILE: sv/fetp_front.sv
`timescale 1ns / 1ps
module fetp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  fetp_pkg::t_pixel       i_pixel,
    input  logic [1:0]             i_mode,
    input  logic [63:0]            i_zoom,
    input  logic signed [63:0]     i_off_re,
    input  logic signed [63:0]     i_off_im,
    input  logic signed [63:0]     i_jul_re,
    input  logic signed [63:0]     i_jul_im,
    output logic                   o_push,
    output fetp_pkg::t_job         o_job,
    input  logic                   i_full
);
    import fetp_pkg::*;

    t_fstate            r_state, n_state;
    logic [PIX_W-1:0]   r_x, r_y;
    logic               r_negx, r_negy, r_zerox, r_zeroy;
    logic signed [63:0] r_mx, r_my;

    logic               w_accept;
    logic signed [MAG_W:0] w_nx, w_ny;
    logic [MAG_W-1:0]   w_magx, w_magy;
    logic [DEN_W-1:0]   w_den_x, w_den_y;
    logic               w_dx_done, w_dx_sat, w_dy_done, w_dy_sat;
    logic [QUO_W-1:0]   w_dx_quo, w_dy_quo;

    function automatic logic signed [63:0] map_coord(input logic zero, input logic neg,
                                                     input logic sat,
                                                     input logic [QUO_W-1:0] quo);
        logic [63:0] m;
        m = {1'b0, quo};
        if (zero) begin
            map_coord = '0;
        end else if (sat) begin
            map_coord = neg ? Q_MIN : Q_MAX;
        end else begin
            map_coord = neg ? (64'd0 - m) : m;
        end
    endfunction

    assign w_accept = (r_state == F_IDLE) && i_valid;

    // n = 2p - size
    assign w_nx   = (MAG_W + 1)'({i_pixel.pixel_x, 1'b0}) - (MAG_W + 1)'(IMG_WIDTH);
    assign w_ny   = (MAG_W + 1)'({i_pixel.pixel_y, 1'b0}) - (MAG_W + 1)'(IMG_HEIGHT);
    assign w_magx = w_nx[MAG_W] ? MAG_W'(-w_nx) : w_nx[MAG_W-1:0];
    assign w_magy = w_ny[MAG_W] ? MAG_W'(-w_ny) : w_ny[MAG_W-1:0];

    // divisor follows the zoom register
    assign w_den_x = DEN_W'(i_zoom) * DEN_W'(DEN_K_X);
    assign w_den_y = DEN_W'(i_zoom) * DEN_W'(DEN_K_Y);

    fetp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_magx),
        .i_den   (w_den_x),
        .o_done  (w_dx_done),
        .o_sat   (w_dx_sat),
        .o_quo   (w_dx_quo)
    );

    fetp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_magy),
        .i_den   (w_den_y),
        .o_done  (w_dy_done),
        .o_sat   (w_dy_sat),
        .o_quo   (w_dy_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= i_pixel.pixel_x;
            r_y     <= i_pixel.pixel_y;
            r_negx  <= w_nx[MAG_W];
            r_negy  <= w_ny[MAG_W];
            r_zerox <= (w_magx == '0);
            r_zeroy <= (w_magy == '0);
        end
        if (r_state == F_ADD) begin
            r_mx <= sadd(map_coord(r_zerox, r_negx, w_dx_sat, w_dx_quo), i_off_re);
            r_my <= sadd(map_coord(r_zeroy, r_negy, w_dy_sat, w_dy_quo), i_off_im);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) n_state = F_DIV;
            end
            F_DIV: begin
                if (w_dx_done && w_dy_done) n_state = F_ADD;
            end
            F_ADD: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // classify by mode: starting z and c
    always_comb begin
        o_stall  = (r_state != F_IDLE);
        o_push   = (r_state == F_PUSH) && !i_full;
        o_job.x  = r_x;
        o_job.y  = r_y;
        o_job.ship = 1'b0;
        o_job.zx = '0;
        o_job.zy = '0;
        o_job.cx = sadd(r_mx, MB_SHIFT_RE);
        o_job.cy = sadd(r_my, MB_SHIFT_IM);
        unique case (t_mode'(i_mode))
            MODE_JULIA: begin
                o_job.zx = r_mx;
                o_job.zy = r_my;
                o_job.cx = i_jul_re;
                o_job.cy = i_jul_im;
            end
            MODE_SHIP: begin
                o_job.ship = 1'b1;
                o_job.cx   = sadd(r_mx, BS_SHIFT_RE);
                o_job.cy   = sadd(r_my, BS_SHIFT_IM);
            end
            default: begin
                o_job.ship = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/fetp_queue.sv
`timescale 1ns / 1ps
module fetp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fetp_pkg::t_job   i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output fetp_pkg::t_job   o_head
);
    import fetp_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QA_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA_W + 1)'(i_push) - (QA_W + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = (r_cnt == (QA_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

endmodule

FILE: sv/fetp_mul.sv
`timescale 1ns / 1ps
module fetp_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_prod
);
    import fetp_pkg::*;

    logic [63:0]  r_a, r_b;
    logic         r_issue, r_pp_v, r_pp_last, r_done;
    logic [1:0]   r_cnt, r_pp_sh;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;

    logic [31:0]  w_ah, w_bh;

    // partial k: a half k[0], b half k[1]
    assign w_ah = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign w_bh = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_pp_v    <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_pp_v    <= r_issue && !i_start;
            r_pp_last <= r_issue && (r_cnt == 2'd3);
            r_done    <= r_pp_v && r_pp_last;
            if (i_start) begin
                r_issue <= 1'b1;
                r_cnt   <= '0;
            end else if (r_issue) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 2'd3) r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp    <= w_ah * w_bh;
        r_pp_sh <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_pp_v) begin
            r_acc <= r_acc + (128'(r_pp) << {r_pp_sh, 5'd0});
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: sv/fetp_back.sv
`timescale 1ns / 1ps
module fetp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    output logic                o_pop,
    input  fetp_pkg::t_job      i_job,
    input  logic [15:0]         i_max_iter,
    output logic                o_valid,
    input  logic                i_stall,
    output fetp_pkg::t_result   o_result
);
    import fetp_pkg::*;

    t_bstate            r_state, n_state;
    logic signed [63:0] r_zx, r_zy, r_cx, r_cy;
    logic               r_ship;
    logic [PIX_W-1:0]   r_x, r_y;
    logic [15:0]        r_iter, r_count;
    logic               r_inside;
    t_result            r_out;
    logic               r_ovalid;

    logic               w_start, w_load, w_finish;
    logic               w_done_xx, w_done_yy, w_done_xy;
    logic [127:0]       w_pxx, w_pyy, w_pxy;
    logic [63:0]        w_ax, w_ay;
    logic signed [63:0] w_sxx, w_syy, w_sxy, w_t, w_xy, w_new_zy;
    logic [64:0]        w_m2;
    logic               w_escape;

    assign w_ax = mag64(r_zx);
    assign w_ay = mag64(r_zy);

    fetp_mul u_mul_xx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_ax), .i_b(w_ax), .o_done(w_done_xx), .o_prod(w_pxx)
    );
    fetp_mul u_mul_yy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_ay), .i_b(w_ay), .o_done(w_done_yy), .o_prod(w_pyy)
    );
    fetp_mul u_mul_xy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_ax), .i_b(w_ay), .o_done(w_done_xy), .o_prod(w_pxy)
    );

    // squares of the current z give both the escape test for the last
    // step and the next step itself
    always_comb begin
        w_sxx    = sq_sat(w_pxx);
        w_syy    = sq_sat(w_pyy);
        w_sxy    = cross_sat(w_pxy, r_zx[63] ^ r_zy[63]);
        w_m2     = {1'b0, w_sxx} + {1'b0, w_syy};
        w_escape = w_m2 > {1'b0, Q_FOUR};
        w_t      = sadd(sadd(w_sxx, 64'sd0 - w_syy), r_cx);
        w_xy     = w_sxy;
        if (r_ship) begin
            w_t  = sat_abs(w_t);
            w_xy = sat_abs(w_xy);
        end
        w_new_zy = sadd(w_xy, r_cy);
        w_finish = ((r_iter != '0) && w_escape) || (r_iter == i_max_iter);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_zx   <= i_job.zx;
            r_zy   <= i_job.zy;
            r_cx   <= i_job.cx;
            r_cy   <= i_job.cy;
            r_ship <= i_job.ship;
            r_x    <= i_job.x;
            r_y    <= i_job.y;
            r_iter <= '0;
        end
        if (r_state == B_EVAL) begin
            if (w_finish) begin
                r_count  <= r_iter;
                r_inside <= (r_iter >= i_max_iter);
            end else begin
                r_zx   <= w_t;
                r_zy   <= w_new_zy;
                r_iter <= r_iter + 1'b1;
            end
        end
        if (w_load) begin
            r_out.out_x        <= r_x;
            r_out.out_y        <= r_y;
            r_out.escape_count <= r_count;
            r_out.inside_set   <= r_inside;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) n_state = B_START;
            end
            B_START: begin
                n_state = B_MUL;
            end
            B_MUL: begin
                if (w_done_xx && w_done_yy && w_done_xy) n_state = B_EVAL;
            end
            B_EVAL: begin
                n_state = w_finish ? B_OUT : B_START;
            end
            B_OUT: begin
                if (!r_ovalid || !i_stall) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == B_IDLE) && !i_empty;
        w_start  = (r_state == B_START);
        w_load   = (r_state == B_OUT) && (!r_ovalid || !i_stall);
        o_valid  = r_ovalid;
        o_result = r_out;
    end

endmodule

FILE: sv/fractal_escape_time_pixel_top.sv
`timescale 1ns / 1ps
// channel   | valid   | stall   | payload      | accepted when
// ----------+---------+---------+--------------+-------------------------
// request   | i_valid | o_stall | i_pixel      | i_valid && !o_stall
// result    | o_valid | i_stall | o_result     | o_valid && !i_stall
// config    | i_cfg_we| -       | i_cfg_idx/data| i_cfg_we
//
// Front end: accept, divide (63 quotient bits, one per cycle in each of two
// restoring dividers, x and y, then the done handoff), offset add, push; a new
// request is accepted only after the push, which waits while the queue is full.
// Back end: per z step, start, four 32x32 partial products per multiplier plus
// accumulate and done, then evaluate; escape_count + 1 passes per request.
// Reset (synchronous, active low) clears control state and sets config registers to their defaults.
// A stalled result sits in the output register; a two-entry job queue lets
// the front keep mapping pixels while the back iterates or waits.
module fractal_escape_time_pixel_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  fetp_pkg::t_pixel                 i_pixel,
    output logic                             o_valid,
    input  logic                             i_stall,
    output fetp_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [fetp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]                      i_cfg_data
);
    import fetp_pkg::*;

    // configuration registers
    logic [1:0]         r_mode;
    logic [15:0]        r_max_iter;
    logic [63:0]        r_zoom;
    logic signed [63:0] r_off_re, r_off_im, r_jul_re, r_jul_im;

    logic               w_push, w_full, w_pop, w_empty;
    t_job               w_job_in, w_job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MANDEL;
            r_max_iter <= 16'd100;
            r_zoom     <= 64'h0000_0001_0000_0000;   // 1.0 in Q32.32
            r_off_re   <= '0;
            r_off_im   <= '0;
            r_jul_re   <= '0;
            r_jul_im   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:   r_mode     <= i_cfg_data[1:0];
                CFG_MAXIT:  r_max_iter <= i_cfg_data[15:0];
                CFG_ZOOM:   r_zoom     <= i_cfg_data;
                CFG_OFF_RE: r_off_re   <= i_cfg_data;
                CFG_OFF_IM: r_off_im   <= i_cfg_data;
                CFG_JUL_RE: r_jul_re   <= i_cfg_data;
                CFG_JUL_IM: r_jul_im   <= i_cfg_data;
                default: ;  // unused index, ignored
            endcase
        end
    end

    // pixel to plane mapping and mode classification
    fetp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pixel  (i_pixel),
        .i_mode   (r_mode),
        .i_zoom   (r_zoom),
        .i_off_re (r_off_re),
        .i_off_im (r_off_im),
        .i_jul_re (r_jul_re),
        .i_jul_im (r_jul_im),
        .o_push   (w_push),
        .o_job    (w_job_in),
        .i_full   (w_full)
    );

    fetp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_job_head)
    );

    // z = z^2 + c iteration with escape test
    fetp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_job      (w_job_head),
        .i_max_iter (r_max_iter),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

endmodule

FILE: sv/fetp_checker.sv
`timescale 1ns / 1ps
module fetp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  fetp_pkg::t_pixel                 i_pixel,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  fetp_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [fetp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]                      i_cfg_data
);
    import fetp_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("stalled result changed");

    a_escape_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.inside_set |-> o_result.escape_count != 16'd0)
        else $error("escaped pixel with zero count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind fractal_escape_time_pixel_top fetp_checker u_fetp_checker (.*);
